// File: rtl/core/prr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg: shared definitions for the polyphase rational resampler
// Request and register codes, default sizes and control bundles.
// ----------------------------------------------------------------------------
package prr_pkg;

	// default sizes
	localparam int DEF_MAX_UP      = 16;
	localparam int DEF_MAX_TAPS    = 64;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_COEF_BITS   = 18;

	// fixed field widths
	localparam int DOWN_LIMIT   = 256;
	localparam int COEF_IDX_W   = 10;
	localparam int BRANCH_W     = 4;
	localparam int UP_REG_W     = 5;
	localparam int DOWN_REG_W   = 9;
	localparam int TAPS_REG_W   = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;

	// request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_COEF  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd2;

	// history ring control
	typedef struct packed {
		logic push;
		logic advance;
		logic clear;
		logic rd_en;
	} hist_ctrl_t;

	// mac unit control
	typedef struct packed {
		logic clr;
		logic take;
	} mac_ctrl_t;

endpackage

// File: rtl/core/prr_coef_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_coef_mem: polyphase coefficient table
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module prr_coef_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 18,
	parameter int AW    = 10
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic signed [WIDTH-1:0] wr_data,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [WIDTH-1:0] rd_data
);

	logic signed [WIDTH-1:0] mem_q [DEPTH];
	logic signed [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/core/prr_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_hist: sample history ring
// Write pointer, fill count and tap addressing relative to the newest sample.
// ----------------------------------------------------------------------------
module prr_hist
	import prr_pkg::*;
#(
	parameter int MAX_TAPS    = DEF_MAX_TAPS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int TW          = $clog2(MAX_TAPS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hist_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic [TW-1:0]                 rd_tap,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);

	localparam int RW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic signed [SAMPLE_BITS-1:0] ring_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic                          ok_q;
	logic [RW-1:0]                 wp_q;
	logic [TW-1:0]                 fill_q;
	logic [TW:0]                   sum;
	logic [TW:0]                   idx;
	logic [RW-1:0]                 rd_addr;

	// ring slot of tap k is (wp - k) mod depth
	always_comb begin
		sum = (TW+1)'(wp_q) + (TW+1)'(MAX_TAPS) - (TW+1)'(rd_tap);
		if (sum >= (TW+1)'(MAX_TAPS)) begin
			idx = sum - (TW+1)'(MAX_TAPS);
		end else begin
			idx = sum;
		end
		rd_addr = RW'(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			ok_q   <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else begin
				if (ctrl.push && fill_q != TW'(MAX_TAPS)) begin
					fill_q <= fill_q + TW'(1);
				end
				if (ctrl.advance) begin
					if (wp_q == RW'(MAX_TAPS - 1)) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + RW'(1);
					end
				end
			end
			if (ctrl.rd_en) begin
				ok_q <= (rd_tap < fill_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			ring_q[wp_q] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= ring_q[rd_addr];
		end
	end

	// slots not pushed since clear read as zero
	assign rd_data = ok_q ? rd_q : '0;

endmodule

// File: rtl/core/prr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_mac: shared multiply-accumulate unit
// Registered product, wide accumulator, round half up and saturate.
// ----------------------------------------------------------------------------
module prr_mac
	import prr_pkg::*;
#(
	parameter int MAX_TAPS    = DEF_MAX_TAPS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [COEF_BITS-1:0]   coef,
	output logic                          busy,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PW = SAMPLE_BITS + COEF_BITS;
	localparam int AW = PW + $clog2(MAX_TAPS + 1) + 1;
	localparam int SH = COEF_BITS - 3;
	localparam logic signed [AW:0] HALF = (AW+1)'(64'sd1 <<< (SH - 1));
	localparam logic signed [AW:0] SMAX = (AW+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [AW:0] SMIN = -SMAX - (AW+1)'(1);

	logic signed [PW-1:0] prod_s2;
	logic                 prod_v_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [AW:0]   rnd;
	logic signed [AW:0]   shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= ctrl.take;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			prod_s2 <= sample * coef;
		end
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
	end

	// floor((acc + half) / 2^SH), then clamp to sample range
	always_comb begin
		rnd = (AW+1)'(acc_q) + HALF;
		shr = rnd >>> SH;
		if (shr > SMAX) begin
			result = SAMPLE_BITS'(SMAX);
		end else if (shr < SMIN) begin
			result = SAMPLE_BITS'(SMIN);
		end else begin
			result = SAMPLE_BITS'(shr);
		end
	end

	assign busy = prod_v_s2;

endmodule

// File: rtl/core/polyphase_rational_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_rational_resampler: rational up/down polyphase fir resampler
// Sequencer around one shared mac, history ring and coefficient table.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request item per handshake.
//   req_type push stores sample_in in the history ring and produces zero or
//   more output items, one per polyphase branch visited; coef write loads
//   coef_table[coef_index]; clear zeroes history, write pointer and phase.
//   output channel (out_valid / out_stall): sample_out, branch_used, last;
//   last marks the final output item of a push.
//   config channel (cfg_valid / cfg_ready): always ready, index 0 up factor,
//   1 down factor, 2 taps per phase; write only while the block is idle.
// timing
//   a coef write or clear never leaves idle. a push walks each visited
//   branch with the single mac unit, one tap per cycle, then drains it and
//   emits one output. in_stall is high while an item is in progress.
// reset and stall
//   reset empties the history (fill count), zeroes pointer and phase and
//   loads up 1, down 1, taps 64; the coefficient table is not cleared.
//   a stalled output holds; the sequencer waits until the register frees.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler
	import prr_pkg::*;
#(
	parameter int MAX_UP      = DEF_MAX_UP,
	parameter int MAX_TAPS    = DEF_MAX_TAPS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [COEF_IDX_W-1:0]         coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [BRANCH_W-1:0]           branch_used,
	output logic                          last,
	// config channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int TW    = $clog2(MAX_TAPS + 1);
	localparam int UW    = $clog2(MAX_UP + 1);
	localparam int DW    = $clog2(DOWN_LIMIT + 1);
	localparam int PHW   = $clog2(MAX_UP + DOWN_LIMIT);
	localparam int CDEP  = MAX_UP * MAX_TAPS;
	localparam int CW    = (CDEP > 1) ? $clog2(CDEP) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]            state_q;
	logic [UP_REG_W-1:0]   up_factor_q;
	logic [DOWN_REG_W-1:0] down_factor_q;
	logic [TAPS_REG_W-1:0] taps_q;

	// clamped values latched per push
	logic [UW-1:0]         up_use_q;
	logic [DW-1:0]         down_use_q;
	logic [TW-1:0]         tpp_use_q;
	logic [UW-1:0]         up_c;
	logic [DW-1:0]         down_c;
	logic [TW-1:0]         tpp_c;

	logic [PHW-1:0]        phase_q;
	logic [PHW-1:0]        phase_nxt;
	logic [TW-1:0]         k_q;
	logic                  rd_v_s1;

	logic                  accept;
	logic                  coef_we;
	logic [31:0]           cidx32;
	logic [CW-1:0]         coef_rd_addr;
	logic                  issue;
	logic                  out_load;

	hist_ctrl_t            hctl;
	mac_ctrl_t             mctl;
	logic signed [SAMPLE_BITS-1:0] hist_data;
	logic signed [COEF_BITS-1:0]   coef_data;
	logic signed [SAMPLE_BITS-1:0] mac_result;
	logic                          mac_busy;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic [BRANCH_W-1:0]           branch_q;
	logic                          last_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;

	// register clamps applied at the start of a push
	always_comb begin
		logic [31:0] u32;
		logic [31:0] d32;
		logic [31:0] t32;
		u32 = 32'(up_factor_q);
		d32 = 32'(down_factor_q);
		t32 = 32'(taps_q);
		up_c   = UW'((u32 == 0) ? 32'd1 : ((u32 > MAX_UP) ? 32'(MAX_UP) : u32));
		down_c = DW'((d32 == 0) ? 32'd1 : ((d32 > DOWN_LIMIT) ? 32'(DOWN_LIMIT) : d32));
		tpp_c  = TW'((t32 == 0) ? 32'd1 : ((t32 > MAX_TAPS) ? 32'(MAX_TAPS) : t32));
	end

	// coefficient index is branch * MAX_TAPS + tap, so it addresses the table directly
	assign cidx32  = 32'(coef_index);
	assign coef_we = accept && (req_type == REQ_COEF) && (cidx32 < 32'(CDEP));

	assign issue        = (state_q == ST_RUN);
	assign coef_rd_addr = CW'(phase_q) * CW'(MAX_TAPS) + CW'(k_q);
	assign phase_nxt    = phase_q + PHW'(down_use_q);
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// history and mac control
	always_comb begin
		hctl.push    = accept && (req_type == REQ_PUSH);
		hctl.clear   = accept && (req_type == REQ_CLEAR);
		hctl.advance = (state_q == ST_CHECK) && !(phase_q < PHW'(up_use_q));
		hctl.rd_en   = issue;
		mctl.clr     = (state_q == ST_CHECK);
		mctl.take    = rd_v_s1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_factor_q   <= UP_REG_W'(1);
			down_factor_q <= DOWN_REG_W'(1);
			taps_q        <= TAPS_REG_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UP:   up_factor_q   <= UP_REG_W'(cfg_data);
				CFG_DOWN: down_factor_q <= DOWN_REG_W'(cfg_data);
				CFG_TAPS: taps_q        <= TAPS_REG_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= '0;
			k_q        <= '0;
			rd_v_s1    <= 1'b0;
			up_use_q   <= UW'(1);
			down_use_q <= DW'(1);
			tpp_use_q  <= TW'(1);
		end else begin
			rd_v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_PUSH) begin
							up_use_q   <= up_c;
							down_use_q <= down_c;
							tpp_use_q  <= tpp_c;
							state_q    <= ST_CHECK;
						end else if (req_type == REQ_CLEAR) begin
							phase_q <= '0;
						end
					end
				end
				ST_CHECK: begin
					// another branch to visit, or close the push
					if (phase_q < PHW'(up_use_q)) begin
						k_q     <= '0;
						state_q <= ST_RUN;
					end else begin
						phase_q <= phase_q - PHW'(up_use_q);
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (k_q == tpp_use_q - TW'(1)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + TW'(1);
					end
				end
				ST_DRAIN: begin
					// wait for read and product stages to empty
					if (!rd_v_s1 && !mac_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						phase_q <= phase_nxt;
						state_q <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= mac_result;
			branch_q     <= BRANCH_W'(phase_q);
			last_q       <= (phase_nxt >= PHW'(up_use_q));
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign branch_used = branch_q;
	assign last        = last_q;

	prr_hist #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TW          (TW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hctl),
		.wr_data (sample_in),
		.rd_tap  (k_q),
		.rd_data (hist_data)
	);

	prr_coef_mem #(
		.DEPTH (CDEP),
		.WIDTH (COEF_BITS),
		.AW    (CW)
	) u_coef (
		.clk     (clk),
		.wr_en   (coef_we),
		.wr_addr (CW'(cidx32)),
		.wr_data (coef_value),
		.rd_en   (issue),
		.rd_addr (coef_rd_addr),
		.rd_data (coef_data)
	);

	prr_mac #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctl),
		.sample (hist_data),
		.coef   (coef_data),
		.busy   (mac_busy),
		.result (mac_result)
	);

`ifndef SYNTH
	// taking a new item means no tap is still in flight
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (!rd_v_s1 && !mac_busy))
		else $error("item taken with mac pipeline busy");

	// an output is formed only from a finished sum
	a_out_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (!rd_v_s1 && !mac_busy))
		else $error("output formed before accumulation ended");

	// every visited branch lies below the up factor in use
	a_branch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (phase_q < PHW'(up_use_q)))
		else $error("output from branch beyond up factor");

	// the last flag returns the sequencer to idle after one check
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (phase_nxt >= PHW'(up_use_q))) |=> ##1 (state_q == ST_IDLE))
		else $error("push did not end after its last output");
`endif

endmodule

// File: dv/tb_polyphase_rational_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphase_rational_resampler: self-checking bench for the resampler
// Loads the coefficient table, runs directed and random request streams over
// several register settings, predicts every output item in a behavioral
// model and compares each field in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_polyphase_rational_resampler;
	import prr_pkg::*;

	// request code that the block must ignore, register index with no register
	localparam logic [1:0]           REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

	// longest push: every branch walks the full window, plus sequencer overhead
	localparam int DRAIN_CYCLES = DEF_MAX_UP * (DEF_MAX_TAPS + 5) + 2;
	localparam int FRAC_BITS    = DEF_COEF_BITS - 3;
	localparam int SMP_MAX      = (1 << (DEF_SAMPLE_BITS - 1)) - 1;
	localparam int SMP_MIN      = -(1 << (DEF_SAMPLE_BITS - 1));
	localparam int TABLE_SIZE   = DEF_MAX_UP * DEF_MAX_TAPS;
	// branch 0 is loaded over the full window, every other branch only over
	// its first taps; settings with more than one branch stay within those
	localparam int SHORT_TAPS   = 4;

	typedef struct {
		logic [1:0]                        kind;
		logic signed [DEF_SAMPLE_BITS-1:0] smp;
		logic [COEF_IDX_W-1:0]             cidx;
		logic signed [DEF_COEF_BITS-1:0]   cval;
	} request_t;

	typedef struct {
		logic signed [DEF_SAMPLE_BITS-1:0] smp;
		logic [BRANCH_W-1:0]               branch;
		logic                              fin;
	} out_sample_t;

	// dut signals, every input driven to a known value from time zero
	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              in_valid   = 1'b0;
	logic                              in_stall;
	logic [1:0]                        req_type   = REQ_PUSH;
	logic signed [DEF_SAMPLE_BITS-1:0] sample_in  = '0;
	logic [COEF_IDX_W-1:0]             coef_index = '0;
	logic signed [DEF_COEF_BITS-1:0]   coef_value = '0;
	logic                              out_valid;
	logic                              out_stall  = 1'b0;
	logic signed [DEF_SAMPLE_BITS-1:0] sample_out;
	logic [BRANCH_W-1:0]               branch_used;
	logic                              last;
	logic                              cfg_valid  = 1'b0;
	logic                              cfg_ready;
	logic [CFG_IDX_W-1:0]              cfg_index  = CFG_UP;
	logic [CFG_DATA_W-1:0]             cfg_data   = '0;

	// shadow of the block state, updated as items and register writes land
	logic signed [DEF_SAMPLE_BITS-1:0] hist [DEF_MAX_TAPS];
	logic signed [DEF_COEF_BITS-1:0]   coefs [TABLE_SIZE];
	int unsigned                       wr_pos = 0;
	int unsigned                       phase  = 0;
	logic [UP_REG_W-1:0]               up_reg   = 1;
	logic [DOWN_REG_W-1:0]             down_reg = 1;
	logic [TAPS_REG_W-1:0]             taps_reg = 64;

	// requests waiting for the driver, outputs waiting for the dut
	request_t    requests_todo [$];
	out_sample_t due_samples [$];
	request_t    cur_req;
	out_sample_t got_want;

	int  queued_cnt   = 0;
	int  accepted_cnt = 0;
	int  results_seen = 0;
	int  errors       = 0;
	int  hold_off     = 0;
	int  stall_left   = 0;
	bit  in_idle_on   = 1'b1;
	bit  out_idle_on  = 1'b1;

	polyphase_rational_resampler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.sample_in  (sample_in),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.branch_used(branch_used),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		foreach (hist[k]) hist[k] = '0;
		foreach (coefs[k]) coefs[k] = '0;
	end

	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// one request through the resampler: updates the shadow state and queues
	// every output item the request causes, in order
	function automatic void resampler_step(input request_t r);
		int unsigned up, down, tpp, n, k;
		longint      acc;
		longint      q;
		out_sample_t o;
		case (r.kind)
			REQ_COEF: begin
				// branch field of a 10-bit index never reaches past the table
				coefs[r.cidx] = r.cval;
			end
			REQ_CLEAR: begin
				foreach (hist[j]) hist[j] = '0;
				wr_pos = 0;
				phase  = 0;
			end
			REQ_PUSH: begin
				// registers are clamped to their legal ranges at use
				up   = clamp_reg(up_reg, DEF_MAX_UP);
				down = clamp_reg(down_reg, DOWN_LIMIT);
				tpp  = clamp_reg(taps_reg, DEF_MAX_TAPS);
				hist[wr_pos] = r.smp;
				n = 0;
				while (phase < up) begin
					// newest sample against tap 0, older ones walk back through the ring
					acc = 0;
					for (k = 0; k < tpp; k++)
						acc += longint'(coefs[phase * DEF_MAX_TAPS + k]) *
							longint'(hist[(wr_pos + DEF_MAX_TAPS - k) % DEF_MAX_TAPS]);
					// the sum cannot come near the 64-bit limit at these widths
					// round half up: add half an lsb then floor-shift
					q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
					if (q > SMP_MAX) q = SMP_MAX;
					if (q < SMP_MIN) q = SMP_MIN;
					o.smp    = q[DEF_SAMPLE_BITS-1:0];
					o.branch = phase[BRANCH_W-1:0];
					o.fin    = 1'b0;
					due_samples.push_back(o);
					n++;
					phase += down;
				end
				// last flag marks the final output of this push
				if (n > 0) due_samples[due_samples.size() - 1].fin = 1'b1;
				phase -= up;
				wr_pos = (wr_pos + 1) % DEF_MAX_TAPS;
			end
			default: ;  // unused request code, nothing changes
		endcase
	endfunction

	// request driver: predicts at each accepted item, then loads the next one
	// or inserts an idle burst
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hold_off <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				resampler_step(cur_req);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				if (hold_off != 0) begin
					hold_off <= hold_off - 1;
					in_valid <= 1'b0;
				end else if (in_idle_on && $urandom_range(0, 5) == 0) begin
					// idle burst starts here, its remaining length in hold_off
					hold_off <= $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (requests_todo.size() != 0) begin
					cur_req = requests_todo.pop_front();
					in_valid   <= 1'b1;
					req_type   <= cur_req.kind;
					sample_in  <= cur_req.smp;
					coef_index <= cur_req.cidx;
					coef_value <= cur_req.cval;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall bursts, counted down in stall_left
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// output monitor: each accepted item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_samples.size() == 0) begin
				$error("output item with none predicted: sample_out %0d branch_used %0d last %0b",
					sample_out, branch_used, last);
				errors++;
			end else begin
				got_want = due_samples.pop_front();
				if (sample_out !== got_want.smp) begin
					$error("sample_out expected %0d got %0d", got_want.smp, sample_out);
					errors++;
				end
				if (branch_used !== got_want.branch) begin
					$error("branch_used expected %0d got %0d", got_want.branch, branch_used);
					errors++;
				end
				if (last !== got_want.fin) begin
					$error("last expected %0b got %0b", got_want.fin, last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers, all called right after a rising edge
	// ------------------------------------------------------------------
	task automatic queue_request(input logic [1:0] kind, input logic [DEF_SAMPLE_BITS-1:0] smp,
		input logic [COEF_IDX_W-1:0] cidx, input logic [DEF_COEF_BITS-1:0] cval);
		request_t r;
		r.kind = kind;
		r.smp  = smp;
		r.cidx = cidx;
		r.cval = cval;
		requests_todo.push_back(r);
		queued_cnt++;
	endtask

	// fields the block does not use for a request carry random bits
	task automatic push_sample(input logic [DEF_SAMPLE_BITS-1:0] s);
		queue_request(REQ_PUSH, s, COEF_IDX_W'($urandom), DEF_COEF_BITS'($urandom));
	endtask

	task automatic write_coef(input logic [COEF_IDX_W-1:0] i, input logic [DEF_COEF_BITS-1:0] v);
		queue_request(REQ_COEF, DEF_SAMPLE_BITS'($urandom), i, v);
	endtask

	task automatic clear_history();
		queue_request(REQ_CLEAR, DEF_SAMPLE_BITS'($urandom), COEF_IDX_W'($urandom),
			DEF_COEF_BITS'($urandom));
	endtask

	task automatic send_unused();
		queue_request(REQ_UNUSED, DEF_SAMPLE_BITS'($urandom), COEF_IDX_W'($urandom),
			DEF_COEF_BITS'($urandom));
	endtask

	// everything accepted and delivered, then let a silent push finish
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || due_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid stays high across back-to-back writes; caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_UP:   up_reg   = data[UP_REG_W-1:0];
			CFG_DOWN: down_reg = data[DOWN_REG_W-1:0];
			CFG_TAPS: taps_reg = data[TAPS_REG_W-1:0];
			default:  ;
		endcase
	endtask

	task automatic set_rates(input int up_v, input int down_v, input int taps_v);
		write_reg(CFG_UP, CFG_DATA_W'(up_v));
		write_reg(CFG_DOWN, CFG_DATA_W'(down_v));
		write_reg(CFG_TAPS, CFG_DATA_W'(taps_v));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return DEF_SAMPLE_BITS'(SMP_MAX);
			1:       return DEF_SAMPLE_BITS'(SMP_MIN);
			2:       return DEF_SAMPLE_BITS'($urandom_range(0, 63) - 32);
			default: return DEF_SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic int one_of(input int a, input int b, input int c, input int d);
		case ($urandom_range(0, 3))
			0:       return a;
			1:       return b;
			2:       return c;
			default: return d;
		endcase
	endfunction

	// run limit, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int i, n, roll, up_v, down_v, taps_v, random_items, results_base;
		logic signed [DEF_COEF_BITS-1:0] cv;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the table powers up undefined, so every entry a push can reach is
		// loaded before any push; mostly modest values so outputs are not all
		// clipped
		for (i = 0; i < TABLE_SIZE; i++) begin
			if (i < DEF_MAX_TAPS || (i % DEF_MAX_TAPS) < SHORT_TAPS) begin
				cv = DEF_COEF_BITS'($urandom);
				cv = cv >>> $urandom_range(3, 9);
				write_coef(COEF_IDX_W'(i), cv);
			end
		end

		// directed: sample extremes at reset rates (up 1, down 1, 64 taps)
		push_sample(DEF_SAMPLE_BITS'(SMP_MAX));
		push_sample(DEF_SAMPLE_BITS'(SMP_MIN));
		push_sample('0);
		push_sample(16'sd1);
		push_sample(-16'sd1);
		// coefficient extremes, including the very last table entry
		write_coef(10'd0, 18'h1FFFF);
		write_coef(10'd1, 18'h20000);
		write_coef(10'd1023, 18'h20000);
		// these two clip high and then low
		push_sample(DEF_SAMPLE_BITS'(SMP_MAX));
		push_sample(DEF_SAMPLE_BITS'(SMP_MIN));
		send_unused();
		// after a clear the window is one sample and zeros
		clear_history();
		push_sample(16'sh4000);
		wait_idle();

		// most outputs per push, every branch visited
		set_rates(16, 1, SHORT_TAPS);
		push_sample(DEF_SAMPLE_BITS'(SMP_MIN));
		push_sample(DEF_SAMPLE_BITS'(SMP_MAX));
		wait_idle();

		// raw zero up and taps, oversized down: clamped to 1, 256 and 1;
		// only the first push gives an output, spare register index is ignored
		write_reg(CFG_UP, '0);
		write_reg(CFG_DOWN, '1);
		write_reg(CFG_TAPS, '0);
		write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		repeat (4) push_sample(pick_sample());
		wait_idle();

		// oversized up, zero down: clamped to 16 and 1
		set_rates(31, 0, SHORT_TAPS);
		clear_history();
		push_sample(pick_sample());
		push_sample(pick_sample());
		wait_idle();

		// oversized taps with one branch: clamped to 64
		set_rates(1, 2, 127);
		push_sample(pick_sample());
		push_sample(pick_sample());
		wait_idle();

		set_rates(3, 2, SHORT_TAPS);
		repeat (3) push_sample(pick_sample());
		wait_idle();

		// random phases: new rates each time, mostly pushes with some table
		// writes, clears and unused codes mixed in
		random_items = 0;
		results_base = results_seen;
		while (random_items < 100 || results_seen - results_base < 48) begin
			if ($urandom_range(0, 9) < 2) begin
				// edges of the register fields, legal or not
				up_v   = one_of(0, 1, 16, 31);
				down_v = one_of(0, 1, 256, 511);
				taps_v = (up_v < 2) ? one_of(0, 1, 64, 127) : one_of(0, 1, 2, SHORT_TAPS);
			end else begin
				up_v   = $urandom_range(1, 16);
				down_v = $urandom_range(1, 2 * up_v + 3);
				taps_v = (up_v == 1) ? $urandom_range(1, 64) : $urandom_range(1, SHORT_TAPS);
			end
			set_rates(up_v, down_v, taps_v);
			in_idle_on  = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(18, 34);
			for (i = 0; i < n; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 84) push_sample(pick_sample());
				else if (roll < 93) write_coef(COEF_IDX_W'($urandom), DEF_COEF_BITS'($urandom));
				else if (roll < 97) clear_history();
				else send_unused();
			end
			random_items += n;
			// sender holds off here until every predicted output is out
			wait_idle();
		end

		// closing stretch at full rate, no idling on either side
		in_idle_on  = 1'b0;
		out_idle_on = 1'b0;
		set_rates($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, SHORT_TAPS));
		repeat (16) push_sample(pick_sample());
		wait_idle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/prr_pkg.sv
rtl/core/prr_coef_mem.sv
rtl/core/prr_hist.sv
rtl/core/prr_mac.sv
rtl/core/polyphase_rational_resampler.sv
dv/tb_polyphase_rational_resampler.sv
